// ===== design/sdau_pkg.sv =====
package sdau_pkg;

    localparam int VALUE_BITS = 32;

    // Decimal digits needed for a magnitude of up to 2^(VALUE_BITS-1).
    // 1233/4096 is a slight underestimate of log10(2).
    localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_BITS   = NUM_DIGITS * 4;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_port_t;

endpackage

// ===== design/sdau_front.sv =====
module sdau_front (
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sdau_pkg::VALUE_BITS-1:0] s_value,
    input  logic                                q_full,
    output sdau_pkg::q_port_t                   q_push
);
    import sdau_pkg::*;

    logic neg;

    // The negation wraps within VALUE_BITS, so the most negative value
    // yields 2^(VALUE_BITS-1) as an unsigned magnitude.
    assign neg               = s_value[VALUE_BITS-1];
    assign s_ready           = !q_full;
    assign q_push.valid      = s_valid && !q_full;
    assign q_push.item.neg   = neg;
    assign q_push.item.mag   = neg ? (~s_value + 1'b1) : s_value;

endmodule

// ===== design/sdau_fifo.sv =====
module sdau_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  sdau_pkg::q_port_t push,
    output logic              full,
    output sdau_pkg::q_port_t head,
    input  logic              pop
);
    import sdau_pkg::*;

    item_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_pop;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push.valid && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push.valid && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

// ===== design/sdau_back.sv =====
module sdau_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  sdau_pkg::q_port_t head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_text_char,
    output logic              m_last_char
);
    import sdau_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_LEAD  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VALUE_BITS - 1);

    logic [2:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] bin_reg;
    logic [BCD_BITS-1:0]   bcd_reg;
    logic [BCD_BITS-1:0]   bcd_adj;
    logic                  neg_reg;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [DIG_IDX_W-1:0]  idx_reg;
    logic [DIG_IDX_W-1:0]  lead_idx;
    logic [3:0]            cur_digit;
    logic                  out_free;
    logic                  m_valid_reg;
    logic [7:0]            m_char_reg;
    logic                  m_last_reg;

    assign out_free    = !m_valid_reg || m_ready;
    assign pop         = (state_reg == ST_IDLE) && head.valid;
    assign m_valid     = m_valid_reg;
    assign m_text_char = m_char_reg;
    assign m_last_char = m_last_reg;
    assign cur_digit   = bcd_reg[idx_reg*4 +: 4];

    // Shift-and-add-3 step: every BCD digit of five or more is bumped by
    // three before the next binary bit is shifted in.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                (bcd_reg[i*4 +: 4] + 4'd3) : bcd_reg[i*4 +: 4];
        end
    end

    // Highest nonzero digit; zero itself still shows one digit.
    always_comb begin
        lead_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] != 4'd0) begin
                lead_idx = DIG_IDX_W'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (head.valid) state_next = ST_CONV;
            ST_CONV:  if (bit_cnt_reg == LAST_BIT) state_next = ST_LEAD;
            ST_LEAD:  state_next = neg_reg ? ST_SIGN : ST_DIGIT;
            ST_SIGN:  if (out_free) state_next = ST_DIGIT;
            ST_DIGIT: if (out_free && idx_reg == '0) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_free) begin
                m_valid_reg <= (state_reg == ST_SIGN) || (state_reg == ST_DIGIT);
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                bin_reg     <= head.item.mag;
                neg_reg     <= head.item.neg;
                bcd_reg     <= '0;
                bit_cnt_reg <= '0;
            end
            ST_CONV: begin
                bcd_reg     <= {bcd_adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
                bin_reg     <= {bin_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            ST_LEAD: begin
                idx_reg <= lead_idx;
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_char_reg <= CH_MINUS;
                    m_last_reg <= 1'b0;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    m_char_reg <= CH_ZERO + {4'd0, cur_digit};
                    m_last_reg <= (idx_reg == '0);
                    idx_reg    <= idx_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/signed_int_to_decimal_ascii_unit.sv =====
// Signed integer to decimal ASCII converter.
//
// The input channel (s_valid, s_ready, s_value) takes one 32-bit two's
// complement integer per item. The output channel (m_valid, m_ready,
// m_text_char, m_last_char) returns its decimal text one character per
// item, most significant first: a leading '-' for negative values, then
// the digits without leading zeros. m_last_char marks the final character.
// Zero gives the single character '0'.
//
// A two-entry queue sits between the input stage and the converter, so up
// to two integers are taken while a conversion or the output is busy.
// The converter runs a shift-and-add-3 loop, one binary bit per cycle. For each
// number it takes a load step, one conversion step per input bit and a step to
// find the leading digit, then gives one character per cycle while the receiver
// takes them; the next number is loaded only once the last character has gone
// to the output register.
//
// When the receiver holds m_ready low, the current character stays on the
// output register and the converter waits. Reset (aresetn low, synchronous)
// empties the queue, drops any character in flight and returns to idle.
module signed_int_to_decimal_ascii_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [sdau_pkg::VALUE_BITS-1:0] s_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [7:0]                             m_text_char,
    output logic                                   m_last_char
);
    import sdau_pkg::*;

    q_port_t q_push;
    q_port_t q_head;
    logic    q_full;
    logic    q_pop;

    sdau_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_value (s_value),
        .q_full  (q_full),
        .q_push  (q_push)
    );

    sdau_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .full    (q_full),
        .head    (q_head),
        .pop     (q_pop)
    );

    sdau_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (q_head),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last_char (m_last_char)
    );

endmodule

// ===== design/sdau_checker.sv =====
module sdau_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_text_char,
    input logic       m_last_char
);
    import sdau_pkg::*;

    // A stalled character must hold until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_text_char) && $stable(m_last_char))
        else $error("output item changed while stalled");

    a_charset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_text_char == CH_MINUS) ||
                    ((m_text_char >= CH_ZERO) && (m_text_char <= CH_NINE)))
        else $error("output character is neither a digit nor a minus sign");

    // The sign is always followed by at least one digit.
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_text_char == CH_MINUS) |-> !m_last_char)
        else $error("minus sign flagged as last character");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind signed_int_to_decimal_ascii_unit sdau_checker u_sdau_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_text_char (m_text_char),
    .m_last_char (m_last_char)
);

// ===== tb/sv/signed_int_to_decimal_ascii_unit_tb.sv =====
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit_tb;

    import sdau_pkg::*;

    localparam int RADIX          = 10;
    localparam int MAX_DIGITS     = 20;
    localparam int DIR_ROWS       = 20;
    localparam int RANDOM_ITEMS   = 190;
    localparam int CALM_ITEMS     = 40;
    localparam int DRAIN_AT_ITEM  = 80;
    localparam int HOLD_AT_VALUES = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } char_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [VALUE_BITS-1:0] s_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_text_char;
    logic                  m_last_char;

    char_t expected_chars [$];
    // One entry per offered item: literal text, or empty to use the predictor.
    string literal_texts [$];

    int errors         = 0;
    int values_taken   = 0;
    int idle_cycles    = 0;
    bit idle_on        = 1'b1;
    bit long_hold_done = 1'b0;

    localparam logic [VALUE_BITS-1:0] DIR_VALUE [DIR_ROWS] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0009,
        32'h0000_000A, 32'hFFFF_FFF6, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h8000_0001, 32'h3B9A_CA00, 32'h3B9A_C9FF, 32'hC465_3600,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'hDEAD_BEEF,
        32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF, 32'h7FFF_FFFE
    };
    string DIR_TEXT [DIR_ROWS] = '{
        "0", "1", "-1", "9",
        "10", "-10", "2147483647", "-2147483648",
        "-2147483647", "1000000000", "999999999", "-1000000000",
        "", "", "", "",
        "", "", "", ""
    };

    signed_int_to_decimal_ascii_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last_char (m_last_char)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Appends the decimal text of one value, sign first, to the expected characters.
    function automatic void queue_decimal_chars(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS:0] mag;
        logic [3:0]          digit [MAX_DIGITS];
        int                  nd;
        int                  i;
        // One extra bit keeps the magnitude of the most negative value.
        mag = v[VALUE_BITS-1] ? {1'b0, ~v} + 1'b1 : {1'b0, v};
        nd = 0;
        do begin
            digit[nd] = 4'(mag % RADIX);
            mag = mag / RADIX;
            nd++;
        end while (mag != 0);
        if (v[VALUE_BITS-1]) begin
            expected_chars.push_back({CH_MINUS, 1'b0});
        end
        for (i = nd - 1; i >= 0; i--) begin
            expected_chars.push_back({CH_ZERO + 8'(digit[i]), i == 0});
        end
    endfunction

    task automatic offer_value(input logic [VALUE_BITS-1:0] v, input string text);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        literal_texts.push_back(text);
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    always @(posedge aclk) begin : monitor
        string txt;
        char_t got;
        char_t want;
        int    i;
        if (aresetn) begin
            idle_cycles++;
            if (m_valid && m_ready) begin
                idle_cycles = 0;
                got = {m_text_char, m_last_char};
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected char: expected none, actual %0d last %0b",
                             $time, got.text, got.last);
                    errors++;
                end else begin
                    want = expected_chars.pop_front();
                    if (got.text !== want.text) begin
                        $display("%0t: text_char mismatch: expected %0d, actual %0d",
                                 $time, want.text, got.text);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last_char mismatch: expected %0b, actual %0b",
                                 $time, want.last, got.last);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                idle_cycles = 0;
                values_taken++;
                txt = literal_texts.pop_front();
                if (txt.len() != 0) begin
                    for (i = 0; i < txt.len(); i++) begin
                        expected_chars.push_back({8'(txt[i]), i == txt.len() - 1});
                    end
                end else begin
                    queue_decimal_chars(s_value);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                $display("signed_int_to_decimal_ascii_unit_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin : receiver
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && values_taken >= HOLD_AT_VALUES) begin
                // Long hold-off so the queue fills and the input side stalls.
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        logic [VALUE_BITS-1:0] v;
        logic [VALUE_BITS-1:0] p;
        int                    sel;
        int                    r;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            offer_value(DIR_VALUE[r], DIR_TEXT[r]);
        end

        for (r = 0; r < RANDOM_ITEMS; r++) begin
            if (r == DRAIN_AT_ITEM) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (expected_chars.size() != 0);
            end
            if (r == RANDOM_ITEMS - CALM_ITEMS) begin
                idle_on = 1'b0;
            end
            // Mix lengths: full-range values, short and medium values, and powers of ten give or take one.
            sel = $urandom_range(0, 3);
            unique case (sel)
                0: v = $urandom();
                1: v = $urandom_range(0, 999);
                2: begin
                    p = 1;
                    repeat ($urandom_range(0, 9)) p = p * RADIX;
                    v = p + $urandom_range(0, 2) - 1;
                end
                default: v = $urandom_range(0, 9999999);
            endcase
            if (sel != 0 && $urandom_range(0, 1) == 1) begin
                v = -v;
            end
            offer_value(v, "");
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (expected_chars.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("signed_int_to_decimal_ascii_unit_tb: PASS");
        end else begin
            $display("signed_int_to_decimal_ascii_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
